// ===== rtl/rple_pkg.sv =====
`timescale 1ns / 1ps

package rple_pkg;

    // Series lengths.
    localparam int LOG_TERMS = 50;
    localparam int EXP_TERMS = 32;

    // Field widths of the transactions.
    localparam int BASE_W   = 32;
    localparam int EXPO_W   = 32;
    localparam int RESULT_W = 64;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Internal value widths (magnitudes, Q.30 unless noted).
    localparam int U_W    = 30;
    localparam int ACC_W  = 32;
    localparam int LNM_W  = 33;
    localparam int W_W    = 37;
    localparam int ZMAG_W = PROD_W - 16;

    // Reciprocal odd table depth and its index width.
    localparam int ODD_DEPTH = 64;
    localparam int LOG_K_W   = $clog2(ODD_DEPTH);

    // Exponential term counter and small-divisor remainder width.
    localparam int EXP_K_W = $clog2(EXP_TERMS + 1);

    // Chunked division of the exponential step.
    localparam int DVD_W      = 72;
    localparam int CHUNK_W    = 8;
    localparam int DIV_CHUNKS = DVD_W / CHUNK_W;

    // Bit-serial divider lengths.
    localparam int CNT_W         = 6;
    localparam int U_DIV_STEPS   = 30;
    localparam int RCP_DIV_STEPS = 33;
    localparam int QUO_W         = RCP_DIV_STEPS;

    // Fixed-point constants.
    localparam logic [63:0]           Q30_ONE      = 64'd1 << 30;
    localparam logic [BASE_W-1:0]     ONE_Q16      = 32'h0001_0000;
    localparam logic [RESULT_W-1:0]   ONE_Q32      = 64'h0000_0001_0000_0000;
    localparam logic [ZMAG_W-1:0]     Z_LIMIT      = ZMAG_W'(64'd64 << 30);
    localparam logic [DVD_W-1:0]      EXP_SAT_LIM  = 72'h00_FFFF_FFFF_0000_0000;
    localparam logic [RESULT_W-1:0]   RCP_REM_INIT = 64'h0000_0000_8000_0000;

    // floor(2^30 / (2j + 1)) for the logarithm series.
    localparam logic [30:0] RECIP_ODD [ODD_DEPTH] = '{
        31'(Q30_ONE / 64'd1),   31'(Q30_ONE / 64'd3),   31'(Q30_ONE / 64'd5),
        31'(Q30_ONE / 64'd7),   31'(Q30_ONE / 64'd9),   31'(Q30_ONE / 64'd11),
        31'(Q30_ONE / 64'd13),  31'(Q30_ONE / 64'd15),  31'(Q30_ONE / 64'd17),
        31'(Q30_ONE / 64'd19),  31'(Q30_ONE / 64'd21),  31'(Q30_ONE / 64'd23),
        31'(Q30_ONE / 64'd25),  31'(Q30_ONE / 64'd27),  31'(Q30_ONE / 64'd29),
        31'(Q30_ONE / 64'd31),  31'(Q30_ONE / 64'd33),  31'(Q30_ONE / 64'd35),
        31'(Q30_ONE / 64'd37),  31'(Q30_ONE / 64'd39),  31'(Q30_ONE / 64'd41),
        31'(Q30_ONE / 64'd43),  31'(Q30_ONE / 64'd45),  31'(Q30_ONE / 64'd47),
        31'(Q30_ONE / 64'd49),  31'(Q30_ONE / 64'd51),  31'(Q30_ONE / 64'd53),
        31'(Q30_ONE / 64'd55),  31'(Q30_ONE / 64'd57),  31'(Q30_ONE / 64'd59),
        31'(Q30_ONE / 64'd61),  31'(Q30_ONE / 64'd63),  31'(Q30_ONE / 64'd65),
        31'(Q30_ONE / 64'd67),  31'(Q30_ONE / 64'd69),  31'(Q30_ONE / 64'd71),
        31'(Q30_ONE / 64'd73),  31'(Q30_ONE / 64'd75),  31'(Q30_ONE / 64'd77),
        31'(Q30_ONE / 64'd79),  31'(Q30_ONE / 64'd81),  31'(Q30_ONE / 64'd83),
        31'(Q30_ONE / 64'd85),  31'(Q30_ONE / 64'd87),  31'(Q30_ONE / 64'd89),
        31'(Q30_ONE / 64'd91),  31'(Q30_ONE / 64'd93),  31'(Q30_ONE / 64'd95),
        31'(Q30_ONE / 64'd97),  31'(Q30_ONE / 64'd99),  31'(Q30_ONE / 64'd101),
        31'(Q30_ONE / 64'd103), 31'(Q30_ONE / 64'd105), 31'(Q30_ONE / 64'd107),
        31'(Q30_ONE / 64'd109), 31'(Q30_ONE / 64'd111), 31'(Q30_ONE / 64'd113),
        31'(Q30_ONE / 64'd115), 31'(Q30_ONE / 64'd117), 31'(Q30_ONE / 64'd119),
        31'(Q30_ONE / 64'd121), 31'(Q30_ONE / 64'd123), 31'(Q30_ONE / 64'd125),
        31'(Q30_ONE / 64'd127)
    };

    // Input and result transactions.
    typedef struct packed {
        logic [BASE_W-1:0]        base;
        logic signed [EXPO_W-1:0] exponent;
    } t_in;

    typedef struct packed {
        logic [RESULT_W-1:0] power_result;
        logic                overflowed;
    } t_out;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_UDIV,
        S_USQ,
        S_U2,
        S_LMUL,
        S_LADD,
        S_LFIN,
        S_ZMUL,
        S_ZCHK,
        S_EMUL_LO,
        S_EMUL_HI,
        S_ESUM,
        S_EDIV,
        S_EUPD,
        S_FIN,
        S_RDIV,
        S_RWB,
        S_DONE
    } t_state;

endpackage

// ===== rtl/real_power_log_exp_series_unit.sv =====
`timescale 1ns / 1ps
// Power unit: returns base^exponent for an unsigned Q16.16 base and a signed
// Q16.16 exponent, as an unsigned Q32.32 result with a saturation flag.
// Input channel: i_in_valid / o_in_ready with i_in_data; output channel:
// o_out_valid / i_out_ready with o_out_data. One result per input.
// Zero base, unit base and zero exponent go straight to the done state, and
// an oversized power skips the exponential series; a negative product of
// ln(base) and the exponent adds a final reciprocal. Most of the work falls
// to the shared 37x32 multiplier, used once per step of the logarithm Horner
// loop and twice per exponential term, to the 30-step bit-serial divide
// forming (x-1)/(x+1), and to the 8-bit-per-cycle division of each
// exponential term by its index.
// One transaction is in work at a time: o_in_ready is high only when the
// sequencer is idle, so a new transaction is accepted in the cycle after the
// previous result is loaded at the earliest. The result register lets the
// next transaction start while a result waits; if the receiver stalls, the
// finished transaction holds in its last state until the register frees up.
// Synchronous reset empties the result register and idles the sequencer.

module real_power_log_exp_series_unit import rple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // State and datapath registers.
    t_state                r_state, n_state;
    logic                  r_neg, n_neg;
    logic                  r_sat, n_sat;
    logic [EXPO_W-1:0]     r_ymag, n_ymag;
    logic [RESULT_W-1:0]   r_rem, n_rem;
    logic [RESULT_W-1:0]   r_dsr, n_dsr;
    logic [QUO_W-1:0]      r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [U_W-1:0]        r_u, n_u;
    logic [U_W-1:0]        r_u2, n_u2;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [LOG_K_W-1:0]    r_k, n_k;
    logic [PROD_W-1:0]     r_prod;
    logic [W_W-1:0]        r_w, n_w;
    logic [RESULT_W-1:0]   r_g, n_g;
    logic [EXP_K_W-1:0]    r_kexp, n_kexp;
    logic [DVD_W-1:0]      r_dvd, n_dvd;
    logic [EXP_K_W-1:0]    r_krem, n_krem;
    logic [RESULT_W-1:0]   r_res, n_res;
    logic                  r_ovf, n_ovf;
    t_out                  r_out;
    logic                  r_out_valid;

    // Combinational helpers.
    logic                  w_in_fire;
    logic                  w_out_load;
    logic                  w_base_zero;
    logic                  w_trivial_one;
    logic                  w_ln_neg;
    logic [BASE_W-1:0]     w_mag;
    logic [BASE_W:0]       w_den;
    logic [MUL_A_W-1:0]    w_mul_a;
    logic [MUL_B_W-1:0]    w_mul_b;
    logic [PROD_W-1:0]     w_mul_p;
    logic [RESULT_W:0]     w_div_shift;
    logic                  w_div_ge;
    logic [RESULT_W:0]     w_div_rem;
    logic [CHUNK_W-1:0]    w_chunk_q;
    logic [EXP_K_W-1:0]    w_chunk_rem;
    logic [ZMAG_W-1:0]     w_zmag;
    logic                  w_z_over;
    logic                  w_e_over;
    logic                  w_cnt_last;

    assign w_in_fire     = i_in_valid && o_in_ready;
    assign w_base_zero   = (i_in_data.base == '0);
    assign w_trivial_one = (i_in_data.base == ONE_Q16) || (i_in_data.exponent == '0);
    assign w_ln_neg      = (i_in_data.base < ONE_Q16);
    assign w_mag         = w_ln_neg ? (ONE_Q16 - i_in_data.base)
                                    : (i_in_data.base - ONE_Q16);
    assign w_den         = {1'b0, i_in_data.base} + {1'b0, ONE_Q16};
    assign w_zmag        = r_prod[PROD_W-1:16];
    assign w_z_over      = (w_zmag > Z_LIMIT);
    assign w_e_over      = (r_dvd >= EXP_SAT_LIM);
    assign w_cnt_last    = (r_cnt == CNT_W'(1));

    // Shared multiplier; its product is registered every cycle.
    assign w_mul_p = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // One restoring step of the bit-serial divider.
    assign w_div_shift = {r_rem, 1'b0};
    assign w_div_ge    = (w_div_shift >= {1'b0, r_dsr});
    assign w_div_rem   = w_div_ge ? (w_div_shift - {1'b0, r_dsr}) : w_div_shift;

    // Eight quotient bits per cycle of the division by the term index.
    always_comb begin
        logic [EXP_K_W:0]   t;
        logic [EXP_K_W-1:0] kr;
        kr        = r_krem;
        w_chunk_q = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            t = {kr, r_dvd[DVD_W-CHUNK_W+i]};
            if (t >= {1'b0, r_kexp}) begin
                t            = t - {1'b0, r_kexp};
                w_chunk_q[i] = 1'b1;
            end
            kr = t[EXP_K_W-1:0];
        end
        w_chunk_rem = kr;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (w_base_zero || w_trivial_one) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_UDIV;
                    end
                end
            end
            S_UDIV: begin
                if (w_cnt_last) begin
                    n_state = S_USQ;
                end
            end
            S_USQ:     n_state = S_U2;
            S_U2:      n_state = S_LMUL;
            S_LMUL:    n_state = S_LADD;
            S_LADD: begin
                n_state = (r_k == LOG_K_W'(1)) ? S_LFIN : S_LMUL;
            end
            S_LFIN:    n_state = S_ZMUL;
            S_ZMUL:    n_state = S_ZCHK;
            S_ZCHK: begin
                n_state = w_z_over ? S_FIN : S_EMUL_LO;
            end
            S_EMUL_LO: n_state = S_EMUL_HI;
            S_EMUL_HI: n_state = S_ESUM;
            S_ESUM:    n_state = S_EDIV;
            S_EDIV: begin
                if (w_cnt_last) begin
                    n_state = S_EUPD;
                end
            end
            S_EUPD: begin
                if (w_e_over || (r_kexp == EXP_K_W'(1))) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_EMUL_LO;
                end
            end
            S_FIN: begin
                n_state = (r_neg && !r_sat) ? S_RDIV : S_DONE;
            end
            S_RDIV: begin
                if (w_cnt_last) begin
                    n_state = S_RWB;
                end
            end
            S_RWB:     n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, result load and multiplier operands.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            S_USQ: begin
                w_mul_a = MUL_A_W'(r_quo[U_W-1:0]);
                w_mul_b = MUL_B_W'(r_quo[U_W-1:0]);
            end
            S_LMUL: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = MUL_B_W'(r_u2);
            end
            S_LFIN: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = MUL_B_W'(r_u);
            end
            S_ZMUL: begin
                // ln magnitude is twice the scaled series product.
                w_mul_a = MUL_A_W'({r_prod[61:30], 1'b0});
                w_mul_b = r_ymag;
            end
            S_EMUL_LO: begin
                w_mul_a = r_w;
                w_mul_b = r_g[31:0];
            end
            S_EMUL_HI: begin
                w_mul_a = r_w;
                w_mul_b = r_g[63:32];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_neg  = r_neg;
        n_sat  = r_sat;
        n_ymag = r_ymag;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_u    = r_u;
        n_u2   = r_u2;
        n_acc  = r_acc;
        n_k    = r_k;
        n_w    = r_w;
        n_g    = r_g;
        n_kexp = r_kexp;
        n_dvd  = r_dvd;
        n_krem = r_krem;
        n_res  = r_res;
        n_ovf  = r_ovf;
        case (r_state)
            S_IDLE: begin
                // Special cases settle at once; otherwise start u = (x-1)/(x+1).
                n_sat  = 1'b0;
                n_ovf  = 1'b0;
                n_res  = w_base_zero ? '0 : ONE_Q32;
                n_neg  = w_ln_neg ^ i_in_data.exponent[EXPO_W-1];
                n_ymag = i_in_data.exponent[EXPO_W-1] ? (~i_in_data.exponent + 1'b1)
                                                      : i_in_data.exponent;
                n_rem  = RESULT_W'(w_mag);
                n_dsr  = RESULT_W'(w_den);
                n_quo  = '0;
                n_cnt  = CNT_W'(U_DIV_STEPS);
            end
            S_UDIV, S_RDIV: begin
                n_rem = w_div_rem[RESULT_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], w_div_ge};
                n_cnt = r_cnt - 1'b1;
            end
            S_USQ: begin
                n_u = r_quo[U_W-1:0];
            end
            S_U2: begin
                // Horner in u^2 starts from the highest-order coefficient.
                n_u2  = r_prod[59:30];
                n_acc = ACC_W'(RECIP_ODD[LOG_K_W'(LOG_TERMS - 1)]);
                n_k   = LOG_K_W'(LOG_TERMS - 1);
            end
            S_LADD: begin
                n_acc = ACC_W'(r_prod[61:30]) + ACC_W'(RECIP_ODD[r_k - 1'b1]);
                n_k   = r_k - 1'b1;
            end
            S_ZCHK: begin
                if (w_z_over) begin
                    n_sat = 1'b1;
                end
                n_w    = w_zmag[W_W-1:0];
                n_g    = ONE_Q32;
                n_kexp = EXP_K_W'(EXP_TERMS);
            end
            S_EMUL_HI: begin
                n_dvd = DVD_W'(r_prod[PROD_W-1:30]);
            end
            S_ESUM: begin
                // Upper partial product weighs 2^32, i.e. 2^2 after the Q.30 drop.
                n_dvd  = r_dvd + DVD_W'({r_prod, 2'b00});
                n_krem = '0;
                n_cnt  = CNT_W'(DIV_CHUNKS);
            end
            S_EDIV: begin
                n_dvd  = {r_dvd[DVD_W-CHUNK_W-1:0], w_chunk_q};
                n_krem = w_chunk_rem;
                n_cnt  = r_cnt - 1'b1;
            end
            S_EUPD: begin
                if (w_e_over) begin
                    n_sat = 1'b1;
                end else begin
                    n_g    = r_dvd[RESULT_W-1:0] + ONE_Q32;
                    n_kexp = r_kexp - 1'b1;
                end
            end
            S_FIN: begin
                if (!r_neg) begin
                    n_res = r_sat ? '1 : r_g;
                    n_ovf = r_sat;
                end else if (r_sat) begin
                    n_res = '0;
                end else begin
                    // Reciprocal floor(2^64 / g) on the bit-serial divider.
                    n_rem = RCP_REM_INIT;
                    n_dsr = r_g;
                    n_quo = '0;
                    n_cnt = CNT_W'(RCP_DIV_STEPS);
                end
            end
            S_RWB: begin
                n_res = RESULT_W'(r_quo);
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_sat  <= n_sat;
        r_ymag <= n_ymag;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_u    <= n_u;
        r_u2   <= n_u2;
        r_acc  <= n_acc;
        r_k    <= n_k;
        r_prod <= w_mul_p;
        r_w    <= n_w;
        r_g    <= n_g;
        r_kexp <= n_kexp;
        r_dvd  <= n_dvd;
        r_krem <= n_krem;
        r_res  <= n_res;
        r_ovf  <= n_ovf;
        if (w_out_load) begin
            r_out.power_result <= r_res;
            r_out.overflowed   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rple_pkg::*;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          PHASE_ITEMS   = 432;
    localparam int          HOLD_CYCLES   = 3000;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          SETTLE_CYCLES = 700;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Z_CEILING     = 64'd64 << 30;
    localparam logic [63:0] Q16_UNIT      = 64'h0000_0000_0001_0000;

    // One row of the directed table: operands, whether the result is typed in, and that result.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] expo;
        logic        typed;
        logic [63:0] power;
        logic        ovf;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // Zero base, including zero to the zero and zero to a negative power.
        '{32'h0000_0000, 32'h0001_0000, 1'b1, 64'h0, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 64'h0, 1'b0},
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 64'h0, 1'b0},
        // Base of exactly one and exponent of zero.
        '{32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 64'h0000_0001_0000_0000, 1'b0},
        '{32'h0001_0000, 32'h8000_0000, 1'b1, 64'h0000_0001_0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 64'h0000_0001_0000_0000, 1'b0},
        '{32'h0000_0001, 32'h0000_0000, 1'b1, 64'h0000_0001_0000_0000, 1'b0},
        // Extreme operands: overflow saturates, underflow goes to zero.
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 64'h0, 1'b0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 64'h0, 1'b0},
        '{32'h0000_0001, 32'h8000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        // Ordinary powers, reciprocal path and the edges of the result range.
        '{32'h0002_0000, 32'h0001_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0000_8000, 32'h0002_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0002_0000, 32'hFFFF_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0004_0000, 32'h0000_8000, 1'b0, 64'h0, 1'b0},
        '{32'h0001_0001, 32'h0000_0001, 1'b0, 64'h0, 1'b0},
        '{32'h0000_FFFF, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{32'h0002_0000, 32'h0020_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0002_0000, 32'h001F_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0002_0000, 32'hFFE0_0000, 1'b0, 64'h0, 1'b0},
        '{32'h0002_0000, 32'h0040_0000, 1'b0, 64'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_1000, 1'b0, 64'h0, 1'b0},
        '{32'h0000_0001, 32'h0001_0000, 1'b0, 64'h0, 1'b0},
        // Power just past the limit of the exponential series.
        '{32'hFFFF_FFFF, 32'h0006_0000, 1'b0, 64'h0, 1'b0}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_out expected_powers [$];
    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    bit   hold_req       = 1'b0;

    real_power_log_exp_series_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Magnitude of ln(base) in Q.30, by Horner's rule over the odd reciprocals in u^2.
    function automatic logic [63:0] ln_magnitude(input logic [31:0] base,
                                                 output logic below_one);
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] acc;
        int          k;
        below_one = ({32'd0, base} < Q16_UNIT);
        mag = below_one ? (Q16_UNIT - {32'd0, base}) : ({32'd0, base} - Q16_UNIT);
        den = {32'd0, base} + Q16_UNIT;
        u   = (mag << 30) / den;
        u2  = (u * u) >> 30;
        acc = Q30_ONE / 64'(2 * (LOG_TERMS - 1) + 1);
        for (k = LOG_TERMS - 1; k > 0; k--) begin
            acc = ((acc * u2) >> 30) + Q30_ONE / 64'(2 * (k - 1) + 1);
        end
        return ((u * acc) >> 30) << 1;
    endfunction

    // e^w for w in Q.30 as a Q32.32 value; each nested term is truncated after the divide.
    function automatic logic [63:0] exp_taylor(input logic [63:0] w, output logic saturated);
        logic [127:0] prod;
        logic [63:0]  acc;
        logic [63:0]  term;
        int           k;
        saturated = 1'b0;
        acc = ONE_Q32;
        for (k = EXP_TERMS; k > 0; k--) begin
            prod = ({64'd0, acc} * {64'd0, w}) / {96'd0, 32'(k)};
            if (prod[127:94] != '0) begin
                saturated = 1'b1;
                return 64'd0;
            end
            term = prod[93:30];
            if (term > ALL_ONES - ONE_Q32) begin
                saturated = 1'b1;
                return 64'd0;
            end
            acc = term + ONE_Q32;
        end
        return acc;
    endfunction

    // Expected result of one input transaction.
    function automatic t_out power_of(input t_in item);
        logic [63:0] e;
        logic [63:0] ymag;
        logic [63:0] lnm;
        logic [63:0] zmag;
        logic [63:0] series;
        logic [63:0] quo;
        logic [63:0] rem;
        logic        ln_neg;
        logic        y_neg;
        logic        z_neg;
        logic        sat;
        t_out        res;
        e = {32'd0, item.exponent};
        res = '0;
        if (item.base == '0) begin
            res.power_result = '0;
        end else if (item.base == ONE_Q16 || e == 64'd0) begin
            res.power_result = ONE_Q32;
        end else begin
            y_neg  = e[31];
            ymag   = y_neg ? (64'h1_0000_0000 - e) : e;
            lnm    = ln_magnitude(item.base, ln_neg);
            z_neg  = (ln_neg != y_neg);
            series = '0;
            sat    = 1'b0;
            if (lnm > ALL_ONES / ymag) begin
                sat = 1'b1;
            end else begin
                zmag = (lnm * ymag) >> 16;
                if (zmag > Z_CEILING) begin
                    sat = 1'b1;
                end else begin
                    series = exp_taylor(zmag, sat);
                end
            end
            if (!z_neg) begin
                if (sat) begin
                    res.power_result = ALL_ONES;
                    res.overflowed   = 1'b1;
                end else begin
                    res.power_result = series;
                end
            end else if (!sat) begin
                // Reciprocal rounds up only when the remainder says 2^64 divides exactly.
                quo = ALL_ONES / series;
                rem = ALL_ONES % series;
                if (rem == series - 64'd1) quo = quo + 64'd1;
                res.power_result = quo;
            end
        end
        return res;
    endfunction

    // Mostly well-formed operands with moderate powers, plus special cases and raw noise.
    function automatic t_in make_random_item();
        t_in it;
        int  pick;
        pick        = $urandom_range(99);
        it.base     = $urandom;
        it.exponent = $urandom;
        if (pick < 3) begin
            it.base = '0;
        end else if (pick < 6) begin
            it.base = ONE_Q16;
        end else if (pick < 9) begin
            it.exponent = '0;
        end else if (pick >= 25) begin
            if ($urandom_range(1) == 1) begin
                it.base = $urandom_range(32'h0008_0000, 1);
            end else begin
                it.base = ($urandom >> $urandom_range(31, 0)) | 32'd1;
            end
            it.exponent = $urandom >> $urandom_range(31, 10);
            if ($urandom_range(1) == 1) it.exponent = -it.exponent;
        end
        return it;
    endfunction

    // Offer one transaction, with an optional idle gap first, and log its expected result.
    task automatic send_item(input t_in item, input logic typed, input t_out typed_val);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_powers.push_back(typed ? typed_val : power_of(item));
    endtask

    // Compare a delivered result with the oldest outstanding expectation.
    task automatic check_power(input t_out got);
        t_out want;
        if (expected_powers.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result %h flag %b", $time, got.power_result,
                     got.overflowed);
        end else begin
            want = expected_powers.pop_front();
            if (got.power_result !== want.power_result) begin
                mismatch_count++;
                $display("%0t: power_result expected %h actual %h", $time,
                         want.power_result, got.power_result);
            end
            if (got.overflowed !== want.overflowed) begin
                mismatch_count++;
                $display("%0t: overflowed expected %b actual %b", $time,
                         want.overflowed, got.overflowed);
            end
        end
    endtask

    // Receiver: checks each result transaction and stalls at random or for one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) check_power(o_out_data);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then drain and verdict.
    initial begin
        int   r;
        int   phase;
        int   n;
        int   drain;
        t_out typed_val;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        stall_pct     = 14;
        for (r = 0; r < DIR_ROWS; r++) begin
            typed_val.power_result = DIRECTED_ROWS[r].power;
            typed_val.overflowed   = DIRECTED_ROWS[r].ovf;
            send_item({DIRECTED_ROWS[r].base, DIRECTED_ROWS[r].expo},
                      DIRECTED_ROWS[r].typed, typed_val);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // Long receiver hold-off so the block backs up onto its input.
                    hold_req = 1'b1;
                end
                1: begin
                    send_idle_pct = 75;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 75;
                end
                default: begin
                    send_idle_pct = 14;
                    stall_pct     = 14;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) send_item(make_random_item(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // Wait for every outstanding result, then let the pipeline settle.
        stall_pct = 0;
        drain = 0;
        while (expected_powers.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_powers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rple_pkg.sv
rtl/real_power_log_exp_series_unit.sv
sim/testbench.sv
